// File: src/dzve_pkg.sv
// ----------------------------------------------------------------------------
// dzve_pkg: shared types and microcode for the delta/zigzag/varint encoder
// Payload structs, control words and the read-only sequencer program.
// ----------------------------------------------------------------------------
package dzve_pkg;

  // Input transaction: one sparse feature.
  typedef struct packed {
    logic [31:0] feature_index;
    logic [31:0] value_bits;
    logic        group_start;
  } feat_t;

  // Output transaction: one encoded byte.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        feature_done;
    logic [31:0] group_byte_count;
  } sym_t;

  localparam logic [31:0] ValPosOne = 32'h3F80_0000;
  localparam logic [31:0] ValNegOne = 32'hBF80_0000;
  localparam logic [31:0] CountMax  = 32'hFFFF_FFFF;
  localparam int          WordW     = 34;  // zigzag << 2 plus flags
  localparam int          StepW     = 3;

  typedef logic [StepW-1:0] step_t;

  // Branch conditions evaluated at the end of a step.
  typedef enum logic [1:0] {
    BR_NEXT    = 2'd0,  // fall through
    BR_ALWAYS  = 2'd1,  // jump to target
    BR_MORE    = 2'd2,  // jump while varint continues
    BR_NOT_GEN = 2'd3   // jump when value is +/-1.0 (no raw bytes)
  } br_t;

  typedef enum logic {
    SRC_VARINT = 1'b0,
    SRC_VALUE  = 1'b1
  } src_t;

  // One control word.
  typedef struct packed {
    logic  accept;   // wait for and load a feature
    logic  emit;     // wait for output slot and emit a byte
    src_t  src;      // byte source
    logic  last;     // marks last value byte
    br_t   br;
    step_t target;
  } ucode_t;

  // Program step addresses.
  localparam step_t StAccept = 3'd0;
  localparam step_t StVarint = 3'd1;
  localparam step_t StCheck  = 3'd2;
  localparam step_t StVal0   = 3'd3;
  localparam step_t StVal1   = 3'd4;
  localparam step_t StVal2   = 3'd5;
  localparam step_t StVal3   = 3'd6;

  // Datapath control from the sequencer.
  typedef struct packed {
    logic load;
    logic emit;
    src_t src;
    logic last;
  } dp_ctl_t;

  // Datapath status back to the sequencer.
  typedef struct packed {
    logic more;       // varint word still >= 128
    logic general;    // raw value bytes follow
    logic slot_free;  // output register can take a byte
  } dp_stat_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t uc;
    uc = '{accept: 1'b0, emit: 1'b0, src: SRC_VARINT, last: 1'b0,
           br: BR_ALWAYS, target: StAccept};
    unique case (s)
      StAccept: uc = '{accept: 1'b1, emit: 1'b0, src: SRC_VARINT, last: 1'b0,
                       br: BR_ALWAYS, target: StVarint};
      StVarint: uc = '{accept: 1'b0, emit: 1'b1, src: SRC_VARINT, last: 1'b0,
                       br: BR_MORE, target: StVarint};
      StCheck:  uc = '{accept: 1'b0, emit: 1'b0, src: SRC_VARINT, last: 1'b0,
                       br: BR_NOT_GEN, target: StAccept};
      StVal0:   uc = '{accept: 1'b0, emit: 1'b1, src: SRC_VALUE, last: 1'b0,
                       br: BR_NEXT, target: StAccept};
      StVal1:   uc = '{accept: 1'b0, emit: 1'b1, src: SRC_VALUE, last: 1'b0,
                       br: BR_NEXT, target: StAccept};
      StVal2:   uc = '{accept: 1'b0, emit: 1'b1, src: SRC_VALUE, last: 1'b0,
                       br: BR_NEXT, target: StAccept};
      StVal3:   uc = '{accept: 1'b0, emit: 1'b1, src: SRC_VALUE, last: 1'b1,
                       br: BR_ALWAYS, target: StAccept};
      default:  uc = '{accept: 1'b0, emit: 1'b0, src: SRC_VARINT, last: 1'b0,
                       br: BR_ALWAYS, target: StAccept};
    endcase
    return uc;
  endfunction

endpackage

// File: src/dzve_seq.sv
// ----------------------------------------------------------------------------
// dzve_seq: microcode sequencer
// Step counter, program ROM lookup and conditional branching.
// ----------------------------------------------------------------------------
module dzve_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              feat_valid,
  input  dzve_pkg::dp_stat_t stat,
  output dzve_pkg::dp_ctl_t  ctl,
  output logic              feat_ready
);

  dzve_pkg::step_t  step;
  dzve_pkg::step_t  step_next;
  dzve_pkg::ucode_t uc;
  logic             go;

  assign uc = dzve_pkg::ucode_rom(step);

  // A step holds while its handshake cannot complete.
  assign go = !((uc.accept && !feat_valid) || (uc.emit && !stat.slot_free));

  assign feat_ready = uc.accept;
  assign ctl.load   = uc.accept && feat_valid;
  assign ctl.emit   = uc.emit && stat.slot_free;
  assign ctl.src    = uc.src;
  assign ctl.last   = uc.last;

  always_comb begin
    step_next = step;
    if (go) begin
      unique case (uc.br)
        dzve_pkg::BR_NEXT:    step_next = step + 1'b1;
        dzve_pkg::BR_ALWAYS:  step_next = uc.target;
        dzve_pkg::BR_MORE:    step_next = stat.more ? uc.target : step + 1'b1;
        dzve_pkg::BR_NOT_GEN: step_next = stat.general ? step + 1'b1 : uc.target;
        default:              step_next = dzve_pkg::StAccept;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dzve_pkg::StAccept;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: src/dzve_dp.sv
// ----------------------------------------------------------------------------
// dzve_dp: encoder datapath
// Delta/zigzag word build, varint and value shifters, byte count, output reg.
// ----------------------------------------------------------------------------
module dzve_dp (
  input  logic               clk,
  input  logic               rst,
  input  dzve_pkg::feat_t    feat,
  input  dzve_pkg::dp_ctl_t  ctl,
  output dzve_pkg::dp_stat_t stat,
  input  logic               sym_ready,
  output logic               sym_valid,
  output dzve_pkg::sym_t     sym
);

  logic [31:0]                prev_index;
  logic [31:0]                byte_total;
  logic [31:0]                byte_total_next;
  logic [dzve_pkg::WordW-1:0] word;
  logic [dzve_pkg::WordW-1:0] word_next;
  logic [31:0]                val;
  logic                       general;
  logic [31:0]                base;
  logic [31:0]                diff;
  logic [31:0]                zz;
  logic                       is_neg_one;
  logic                       is_general;

  // Word build at load.
  assign base       = feat.group_start ? 32'd0 : prev_index;
  assign diff       = feat.feature_index - base;
  assign zz         = {diff[30:0], 1'b0} ^ {32{diff[31]}};
  assign is_neg_one = (feat.value_bits == dzve_pkg::ValNegOne);
  assign is_general = !is_neg_one && (feat.value_bits != dzve_pkg::ValPosOne);
  assign word_next  = {zz, is_general, is_neg_one};

  assign stat.more      = (word[dzve_pkg::WordW-1:7] != '0);
  assign stat.general   = general;
  assign stat.slot_free = !sym_valid || sym_ready;

  assign byte_total_next = (byte_total == dzve_pkg::CountMax) ? byte_total
                                                              : byte_total + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_index <= '0;
      byte_total <= '0;
      sym_valid  <= 1'b0;
    end else begin
      if (ctl.load) begin
        prev_index <= feat.feature_index;
        if (feat.group_start) begin
          byte_total <= '0;
        end
      end
      if (ctl.emit) begin
        byte_total <= byte_total_next;
        sym_valid  <= 1'b1;
      end else if (sym_ready) begin
        sym_valid  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word    <= word_next;
      val     <= feat.value_bits;
      general <= is_general;
    end
    if (ctl.emit) begin
      sym.group_byte_count <= byte_total_next;
      if (ctl.src == dzve_pkg::SRC_VARINT) begin
        sym.out_byte     <= {stat.more, word[6:0]};
        sym.feature_done <= !stat.more && !general;
        word             <= word >> 7;
      end else begin
        sym.out_byte     <= val[7:0];
        sym.feature_done <= ctl.last;
        val              <= val >> 8;
      end
    end
  end

endmodule

// File: src/delta_zigzag_varint_feature_encoder_core.sv
// ----------------------------------------------------------------------------
// delta_zigzag_varint_feature_encoder_core: sparse feature byte encoder
// Delta-codes hashed indices, zigzags them, emits base-128 varints plus
// raw float bytes for general values.
// ----------------------------------------------------------------------------
// Usage:
//   feat channel (feat_valid/feat_ready/feat): one transaction per sparse
//   feature. group_start clears the previous index and the byte count
//   before that feature is encoded.
//   sym channel (sym_valid/sym_ready/sym): one transaction per encoded byte,
//   varint bytes first, then four value bytes (LSB first) unless the value
//   is exactly +1.0 or -1.0. feature_done marks the last byte of a feature.
//   Steps: a microcoded sequencer spends one step accepting the feature,
//   one step per varint byte (1..5), one step on the raw-value branch and
//   one step per value byte (0 or 4). The first byte is loaded into the
//   output register by the varint step that follows the accept step, once
//   the output register is free.
//   The output register frees the sequencer: a byte waiting on sym_ready
//   does not block work until the next byte is due; then the step holds.
//   Reset clears the step counter, previous index, byte count and the
//   output valid; the block then waits for a feature.
// ----------------------------------------------------------------------------
module delta_zigzag_varint_feature_encoder_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            feat_valid,
  output logic            feat_ready,
  input  dzve_pkg::feat_t feat,
  output logic            sym_valid,
  input  logic            sym_ready,
  output dzve_pkg::sym_t  sym
);

  // Control words from the program ROM, status back from the datapath.
  dzve_pkg::dp_ctl_t  ctl;
  dzve_pkg::dp_stat_t stat;

  dzve_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .feat_valid (feat_valid),
    .stat       (stat),
    .ctl        (ctl),
    .feat_ready (feat_ready)
  );

  dzve_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .feat      (feat),
    .ctl       (ctl),
    .stat      (stat),
    .sym_ready (sym_ready),
    .sym_valid (sym_valid),
    .sym       (sym)
  );

  // Sequencer sits in the load step for exactly one accepted transaction.
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    (feat_valid && feat_ready) |=> !feat_ready)
    else $error("feature accepted twice in a row");

  // A byte that is not the last of its feature means more bytes are owed.
  a_no_early_ready: assert property (@(posedge clk) disable iff (rst)
    (sym_valid && !sym.feature_done) |-> !feat_ready)
    else $error("ready for a new feature before the last byte");

  // Every emitted byte is counted.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    sym_valid |-> (sym.group_byte_count != 32'd0))
    else $error("byte emitted with zero group count");

  // Output register never loads while a byte is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (sym_valid && !sym_ready) |-> !ctl.emit)
    else $error("output register overwritten while stalled");

endmodule
